// File: hdl/bdq_pkg.sv
// Shared types and constants for the bounded deque core.
package bdq_pkg;

  localparam int OP_W       = 3;
  localparam int VALUE_W    = 32;
  localparam int POS_W      = 4;
  localparam int WORD_OUT_W = 32;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_VALUE = 3'd3,
    OP_PEEK      = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_EMPTY     = 3'd1,
    STATUS_NOT_FOUND = 3'd2,
    STATUS_RANGE     = 3'd3,
    STATUS_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_CAPTURE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } ctl_state_t;

  typedef enum logic [1:0] {
    RD_FRONT,
    RD_PEEK,
    RD_NEXT,
    RD_NEXT2
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_FRONT,
    WR_BACK,
    WR_SHIFT
  } wr_sel_t;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_PUSH_FRONT,
    UPD_PUSH_BACK,
    UPD_POP,
    UPD_DROP
  } upd_t;

  typedef struct packed {
    logic    load_req;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    idx_inc;
    logic    cap_word;
    logic    set_st;
    status_t st_code;
    logic    finish;
    upd_t    upd;
  } bdq_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic range_err;
    logic match;
    logic more;
    logic more2;
    logic st_ok;
    logic out_free;
  } bdq_sts_t;

endpackage

// File: hdl/bounded_deque_with_value_removal_core.sv
// Top level of the bounded deque core with removal by value.
// The core holds up to DEPTH words in a ring held in a memory with one write and one
// registered read port, and it works on one request at a time. An insert passes through the
// decide and finish states, a remove-front or a peek through decide, capture and finish. A
// remove-by-value walks the memory one entry per cycle, first to find the match and then to
// move every later entry one place toward the front, so its walk covers at most DEPTH
// entries. A new item is accepted as soon as the result of the previous one is in the
// output register, even while that result waits to be taken.
module bounded_deque_with_value_removal_core
  import bdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // operation[2:0], value[34:3], position[38:35], zero[39]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // word[31:0], status[34:32], count[39:35]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  bdq_cmd_t cmd;
  bdq_sts_t sts;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bdq_dpath #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// File: hdl/bdq_dpath.sv
// Datapath of the bounded deque: entry memory, ring pointers, request and result registers.
module bdq_dpath
  import bdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  bdq_cmd_t               cmd,
  output bdq_sts_t               sts
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SW   = CW + 1;
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [SW:0]   DEPTH_S = (SW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [WORD_WIDTH-1:0] mem [DEPTH];
  logic [WORD_WIDTH-1:0] rd_data_r;

  op_t                   op_r;
  logic [WORD_WIDTH-1:0] val_r;
  logic [POS_W-1:0]      pos_r;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         idx_r;
  logic [WORD_WIDTH-1:0] word_r;
  status_t               st_r;

  logic                  out_valid_r;
  logic [WORD_OUT_W-1:0] out_word_r;
  status_t               out_status_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic [SW-1:0] idx_p1, idx_p2, rd_off, wr_off;
  logic [SW:0]   rd_sum, wr_sum, rd_wrap, wr_wrap;
  logic [AW-1:0] rd_addr, wr_addr, head_dec, head_inc;
  logic [WORD_WIDTH-1:0] wr_data;

  assign idx_p1   = SW'(idx_r) + SW'(1);
  assign idx_p2   = SW'(idx_r) + SW'(2);
  assign head_dec = (head_r == '0) ? LAST_SLOT : head_r - AW'(1);
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + AW'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_FRONT: rd_off = '0;
      RD_PEEK:  rd_off = SW'(pos_r);
      RD_NEXT:  rd_off = idx_p1;
      RD_NEXT2: rd_off = idx_p2;
      default:  rd_off = '0;
    endcase
  end

  assign rd_sum  = (SW+1)'(head_r) + (SW+1)'(rd_off);
  assign rd_wrap = (rd_sum >= DEPTH_S) ? rd_sum - DEPTH_S : rd_sum;
  assign rd_addr = rd_wrap[AW-1:0];

  always_comb begin
    case (cmd.wr_sel)
      WR_BACK:  wr_off = SW'(count_r);
      WR_SHIFT: wr_off = SW'(idx_r);
      default:  wr_off = '0;
    endcase
  end

  assign wr_sum  = (SW+1)'(head_r) + (SW+1)'(wr_off);
  assign wr_wrap = (wr_sum >= DEPTH_S) ? wr_sum - DEPTH_S : wr_sum;

  always_comb begin
    case (cmd.wr_sel)
      WR_FRONT: begin
        wr_addr = head_dec;
        wr_data = val_r;
      end
      WR_BACK: begin
        wr_addr = wr_wrap[AW-1:0];
        wr_data = val_r;
      end
      WR_SHIFT: begin
        wr_addr = wr_wrap[AW-1:0];
        wr_data = rd_data_r;
      end
      default: begin
        wr_addr = wr_wrap[AW-1:0];
        wr_data = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    case (cmd.upd)
      UPD_PUSH_FRONT: begin
        head_nxt  = head_dec;
        count_nxt = count_r + CW'(1);
      end
      UPD_PUSH_BACK: count_nxt = count_r + CW'(1);
      UPD_POP: begin
        head_nxt  = head_inc;
        count_nxt = count_r - CW'(1);
      end
      UPD_DROP: count_nxt = count_r - CW'(1);
      default: begin
        head_nxt  = head_r;
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.finish) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r   <= op_t'(in_tdata[OP_W-1:0]);
      val_r  <= WORD_WIDTH'(in_tdata[OP_W +: VALUE_W]);
      pos_r  <= in_tdata[OP_W+VALUE_W +: POS_W];
      idx_r  <= '0;
      word_r <= '0;
      st_r   <= STATUS_OK;
    end else begin
      if (cmd.idx_inc) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.cap_word) begin
        word_r <= rd_data_r;
      end
      if (cmd.set_st) begin
        st_r <= cmd.st_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_word_r   <= WORD_OUT_W'(word_r);
      out_status_r <= st_r;
      out_count_r  <= COUNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_status_r, out_word_r};

  assign sts.op        = op_r;
  assign sts.full      = (count_r == DEPTH_C);
  assign sts.empty     = (count_r == '0);
  assign sts.range_err = (CMPW'(pos_r) >= CMPW'(count_r));
  assign sts.match     = (rd_data_r == val_r);
  assign sts.more      = (idx_p1 < SW'(count_r));
  assign sts.more2     = (idx_p2 < SW'(count_r));
  assign sts.st_ok     = (st_r == STATUS_OK);
  assign sts.out_free  = !out_valid_r || out_tready;

endmodule

// File: hdl/bdq_ctrl.sv
// Controller state machine that sequences each deque request through the datapath.
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  bdq_sts_t sts,
  output bdq_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (sts.op)
          OP_REM_FRONT: state_nxt = sts.empty ? S_FINISH : S_CAPTURE;
          OP_PEEK:      state_nxt = sts.range_err ? S_FINISH : S_CAPTURE;
          OP_REM_VALUE: state_nxt = sts.empty ? S_FINISH : S_SCAN;
          default:      state_nxt = S_FINISH;
        endcase
      end
      S_CAPTURE: state_nxt = S_FINISH;
      S_SCAN: begin
        if (sts.match) begin
          state_nxt = sts.more ? S_SHIFT : S_FINISH;
        end else begin
          state_nxt = sts.more ? S_SCAN : S_FINISH;
        end
      end
      S_SHIFT: state_nxt = sts.more2 ? S_SHIFT : S_FINISH;
      S_FINISH: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.rd_sel  = RD_FRONT;
    cmd.wr_sel  = WR_FRONT;
    cmd.st_code = STATUS_OK;
    cmd.upd     = UPD_NONE;
    in_tready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready    = 1'b1;
        cmd.load_req = in_tvalid;
      end
      S_DECIDE: begin
        case (sts.op)
          OP_INS_FRONT, OP_INS_BACK: begin
            cmd.set_st  = sts.full;
            cmd.st_code = STATUS_FULL;
          end
          OP_REM_FRONT: begin
            cmd.set_st  = sts.empty;
            cmd.st_code = STATUS_EMPTY;
            cmd.rd_en   = !sts.empty;
            cmd.rd_sel  = RD_FRONT;
          end
          OP_PEEK: begin
            cmd.set_st  = sts.range_err;
            cmd.st_code = STATUS_RANGE;
            cmd.rd_en   = !sts.range_err;
            cmd.rd_sel  = RD_PEEK;
          end
          OP_REM_VALUE: begin
            cmd.set_st  = 1'b1;
            cmd.st_code = STATUS_NOT_FOUND;
            cmd.rd_en   = !sts.empty;
            cmd.rd_sel  = RD_FRONT;
          end
          default: cmd.set_st = 1'b0;
        endcase
      end
      S_CAPTURE: cmd.cap_word = 1'b1;
      S_SCAN: begin
        cmd.rd_en  = sts.more;
        cmd.rd_sel = RD_NEXT;
        if (sts.match) begin
          cmd.cap_word = 1'b1;
          cmd.set_st   = 1'b1;
          cmd.st_code  = STATUS_OK;
        end else begin
          cmd.idx_inc = sts.more;
        end
      end
      S_SHIFT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_SHIFT;
        cmd.idx_inc = 1'b1;
        cmd.rd_en   = sts.more2;
        cmd.rd_sel  = RD_NEXT2;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          if (sts.st_ok) begin
            case (sts.op)
              OP_INS_FRONT: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_FRONT;
                cmd.upd    = UPD_PUSH_FRONT;
              end
              OP_INS_BACK: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_BACK;
                cmd.upd    = UPD_PUSH_BACK;
              end
              OP_REM_FRONT: cmd.upd = UPD_POP;
              OP_REM_VALUE: cmd.upd = UPD_DROP;
              default:      cmd.upd = UPD_NONE;
            endcase
          end
        end
      end
      default: in_tready = 1'b0;
    endcase
  end

endmodule

// File: dv/bounded_deque_with_value_removal_core_test.sv
// Self-checking testbench for the bounded deque core with removal by value.
module bounded_deque_with_value_removal_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  localparam int CAPACITY = 16;
  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 2000;
  localparam logic [OP_W-1:0] OP_SPARE_LO = OP_W'(OP_PEEK) + OP_W'(1);
  localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

  typedef struct {
    logic [WORD_OUT_W-1:0] word;
    status_t               status;
    logic [COUNT_W-1:0]    count;
  } deque_result_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [VALUE_W-1:0] deque_words[$];
  deque_result_t      pending_results[$];

  bit idle_en = 1'b1;
  bit hold_req = 1'b0;
  bit hold_req_d = 1'b0;
  int hold_left = 0;
  int failures = 0;
  int items_sent = 0;
  int results_checked = 0;
  int inserts = 0;
  int removals = 0;
  int peeks = 0;
  int spare_ops = 0;
  int full_hits = 0;
  int value_hits = 0;
  int quiet_cycles = 0;

  bounded_deque_with_value_removal_core #(
    .DEPTH(CAPACITY),
    .WORD_WIDTH(VALUE_W)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit take_break();
    return idle_en && ($urandom_range(99) < 35);
  endfunction

  function automatic void deque_apply(input logic [OP_W-1:0] op,
                                      input logic [VALUE_W-1:0] value,
                                      input logic [POS_W-1:0] pos);
    deque_result_t r;
    bit found;
    r.word = '0;
    r.status = STATUS_OK;
    found = 1'b0;
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        inserts++;
        if (deque_words.size() >= CAPACITY) begin
          r.status = STATUS_FULL;
          full_hits++;
        end else if (op == OP_INS_FRONT) begin
          deque_words.push_front(value);
        end else begin
          deque_words.push_back(value);
        end
      end
      OP_REM_FRONT: begin
        removals++;
        if (deque_words.size() == 0) r.status = STATUS_EMPTY;
        else r.word = deque_words.pop_front();
      end
      OP_REM_VALUE: begin
        removals++;
        r.status = STATUS_NOT_FOUND;
        for (int i = 0; i < deque_words.size(); i++) begin
          if (!found && deque_words[i] == value) begin
            found = 1'b1;
            r.word = deque_words[i];
            r.status = STATUS_OK;
            deque_words.delete(i);
            value_hits++;
          end
        end
      end
      OP_PEEK: begin
        peeks++;
        if (pos >= deque_words.size()) r.status = STATUS_RANGE;
        else r.word = deque_words[pos];
      end
      default: spare_ops++;
    endcase
    r.count = COUNT_W'(deque_words.size());
    pending_results.push_back(r);
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                           input logic [POS_W-1:0] pos);
    while (take_break()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, pos, value, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    deque_apply(op, value, pos);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(4))
      0: return $urandom_range(7);
      1: return $urandom_range(1) ? '1 : '0;
      2, 3: begin
        if (deque_words.size() != 0)
          return deque_words[$urandom_range(deque_words.size() - 1)];
        return $urandom();
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic test_empty_store();
    send_item(OP_REM_FRONT, 32'h0, 4'd0);
    send_item(OP_REM_VALUE, 32'h0, 4'd0);
    send_item(OP_PEEK, 32'hFFFF_FFFF, 4'd0);
    send_item(OP_PEEK, 32'h0, 4'hF);
    send_item(OP_SPARE_LO, 32'hFFFF_FFFF, 4'hF);
    send_item(OP_SPARE_HI, 32'h0, 4'd0);
  endtask

  task automatic test_basic_ops();
    send_item(OP_INS_BACK, 32'h0, 4'hF);
    send_item(OP_INS_FRONT, 32'hFFFF_FFFF, 4'd0);
    send_item(OP_INS_BACK, 32'h1234_5678, 4'd0);
    for (int p = 0; p < 4; p++) send_item(OP_PEEK, $urandom(), POS_W'(p));
    send_item(OP_REM_VALUE, 32'h0, 4'd0);
    send_item(OP_REM_VALUE, 32'hDEAD_BEEF, 4'd0);
    send_item(OP_SPARE_LO + OP_W'(1), 32'hA5A5_A5A5, 4'h5);
    send_item(OP_REM_FRONT, 32'h0, 4'd0);
    send_item(OP_REM_VALUE, 32'h1234_5678, 4'd0);
  endtask

  task automatic test_fill_and_drain();
    for (int n = 0; n < CAPACITY; n++)
      send_item(OP_INS_BACK, $urandom_range(5), POS_W'($urandom()));
    send_item(OP_INS_FRONT, 32'hFFFF_FFFF, 4'd0);
    send_item(OP_INS_BACK, 32'h0, 4'hF);
    send_item(OP_PEEK, 32'h0, 4'hF);
    send_item(OP_PEEK, 32'h0, 4'd0);
    send_item(OP_REM_VALUE, deque_words[CAPACITY - 1], 4'd0);
    send_item(OP_REM_VALUE, deque_words[0], 4'd0);
    send_item(OP_REM_VALUE, 32'h8000_0000, 4'd0);
    send_item(OP_INS_FRONT, 32'h5555_5555, 4'd0);
    send_item(OP_INS_FRONT, 32'hAAAA_AAAA, 4'd0);
    send_item(OP_INS_FRONT, 32'h0, 4'd0);
    while (deque_words.size() != 0)
      send_item(OP_REM_FRONT, $urandom(), POS_W'($urandom()));
    send_item(OP_REM_FRONT, 32'h0, 4'd0);
  endtask

  task automatic random_item();
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    int r;
    r = $urandom_range(99);
    pos = POS_W'($urandom());
    if (r < 3) op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    else if (r < 15) op = OP_PEEK;
    else if (r < 40) op = OP_REM_VALUE;
    else if (r < 55) op = OP_REM_FRONT;
    else op = $urandom_range(1) ? OP_INS_FRONT : OP_INS_BACK;
    if (op == OP_PEEK && deque_words.size() != 0 && $urandom_range(1))
      pos = POS_W'($urandom_range(deque_words.size() - 1));
    send_item(op, pick_value(), pos);
  endtask

  task automatic test_output_stall();
    hold_req <= 1'b1;
    for (int n = 0; n < 30; n++) random_item();
    hold_req <= 1'b0;
  endtask

  task automatic test_random_mix(input int n_items);
    bit filling;
    logic [OP_W-1:0] op;
    filling = 1'b1;
    for (int n = 0; n < n_items; n++) begin
      idle_en = !(n >= 300 && n < 450);
      if (deque_words.size() == CAPACITY && $urandom_range(7) == 0) filling = 1'b0;
      if (deque_words.size() == 0 && $urandom_range(7) == 0) filling = 1'b1;
      if ($urandom_range(99) < (filling ? 35 : 5)) begin
        op = $urandom_range(1) ? OP_INS_FRONT : OP_INS_BACK;
        send_item(op, pick_value(), POS_W'($urandom()));
      end else begin
        random_item();
      end
    end
    idle_en = 1'b1;
  endtask

  task automatic finish_run();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);
    $display("Sent %0d items (%0d inserts, %0d removals, %0d peeks, %0d unused codes).",
             items_sent, inserts, removals, peeks, spare_ops);
    $display("Checked %0d results; %0d inserts hit a full store, %0d removals by value hit.",
             results_checked, full_hits, value_hits);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  endtask

  always @(posedge clk) begin : result_check
    deque_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("Result with no request waiting: tdata=%h", out_tdata);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[WORD_OUT_W-1:0] !== want.word) begin
          $error("word: expected %h, got %h", want.word, out_tdata[WORD_OUT_W-1:0]);
          failures++;
        end
        if (out_tdata[WORD_OUT_W +: STATUS_W] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status,
                 out_tdata[WORD_OUT_W +: STATUS_W]);
          failures++;
        end
        if (out_tdata[WORD_OUT_W + STATUS_W +: COUNT_W] !== want.count) begin
          $error("count: expected %0d, got %0d", want.count,
                 out_tdata[WORD_OUT_W + STATUS_W +: COUNT_W]);
          failures++;
        end
        results_checked++;
      end
    end
    hold_req_d <= hold_req;
    if (hold_req && !hold_req_d) begin
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !take_break();
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $error("No item moved for %0d cycles.", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_store();
    test_basic_ops();
    test_fill_and_drain();
    test_output_stall();
    test_random_mix(1000);
    finish_run();
  end

endmodule
